/* hdl/cpec_pkg.sv */
// ----------------------------------------------------------------------------
// cpec_pkg
// types and helpers shared by the circle pair elastic collision core
// ----------------------------------------------------------------------------
package cpec_pkg;

    // one pair of circles, signed q16.16 positions and velocities
    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic        [23:0] a_radius;
        logic        [31:0] a_mass;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic        [23:0] b_radius;
        logic        [31:0] b_mass;
    } cpec_pair_t;

    // resolved pair
    typedef struct packed {
        logic               collided;
        logic               coincident;
        logic signed [31:0] new_a_pos_x;
        logic signed [31:0] new_a_pos_y;
        logic signed [31:0] new_a_vel_x;
        logic signed [31:0] new_a_vel_y;
        logic signed [31:0] new_b_pos_x;
        logic signed [31:0] new_b_pos_y;
        logic signed [31:0] new_b_vel_x;
        logic signed [31:0] new_b_vel_y;
    } cpec_result_t;

    // originals and decisions carried to the output stage
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic               collided;
        logic               coincident;
        logic               neg_x;
        logic               neg_y;
        logic               neg_dot;
    } cpec_keep_t;

    localparam int NEAR_W = 25;   // centres closer than 2^25 on both axes
    localparam int SUM_W  = 25;   // radius sum
    localparam int D2_W   = 51;   // squared distance
    localparam int LIM2_W = 50;
    localparam int PRD_W  = 59;   // one dot product term
    localparam int DOT_W  = 60;
    localparam int HALF_W = 30;   // dot split for the first product
    localparam int ROOT_W = 26;   // floor(sqrt(d2))
    localparam int P_W    = 85;   // |e| * |dot|
    localparam int Q_W    = 64;   // kept quotient bits
    localparam int MO_W   = 33;   // twice the other mass, mass sum
    localparam int M_W    = 98;   // scaled velocity numerator
    localparam int PN_W   = 52;   // push numerator
    localparam int PD_W   = 27;   // push denominator
    localparam int SH_W   = 26;   // push magnitude

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hdl/circle_pair_elastic_collision_core.sv */
// ----------------------------------------------------------------------------
// circle_pair_elastic_collision_core
// overlap test, push-apart and 2d elastic velocity update for a circle pair
// ----------------------------------------------------------------------------
//
//  channel   ports                 direction  flow
//  pair      start, busy, pair     in         taken when start && !busy
//  result    done, result          out        done flags each item, no stall
//
//  1 item per cycle sustained; busy is always low
//  latency is set by the velocity path: a bit-serial pipelined divide of
//  |e|*|dot|*2^FRAC_BITS by d2 (85+FRAC_BITS stages), then a 98-stage
//  divide by the mass sum; the push path (26-stage root, 52-stage divide)
//  runs alongside and waits in a register line
//  reset clears only the valid line; data registers carry no reset
//
module circle_pair_elastic_collision_core
    import cpec_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int OVERLAP_EPSILON = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cpec_pair_t   pair,
    output logic         done,
    output cpec_result_t result
);

    // stage timing, counted in register stages after the item is taken
    localparam int NQ_W  = P_W + FRAC_BITS;           // first divide numerator
    localparam int DR_W  = MO_W + FRAC_BITS;          // mass sum divisor
    localparam int T_S3  = 3;
    localparam int T_Q   = 5 + NQ_W;                  // first quotient ready
    localparam int T_R   = T_Q + 2 + M_W;             // velocity change ready
    localparam int T_SH  = T_S3 + ROOT_W + 2 + PN_W;  // push ready
    localparam int LAT   = T_R + 1;
    localparam int KW    = $bits(cpec_keep_t);
    localparam logic [SUM_W-1:0] EPS = SUM_W'(OVERLAP_EPSILON);

    // pipeline never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // valid line
    // ------------------------------------------------------------------
    logic [LAT:1] valid_reg;
    logic [LAT:1] valid_next;

    assign valid_next = {valid_reg[LAT-1:1], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: differences, near test, radius sum, mass fix
    // ------------------------------------------------------------------
    logic signed [32:0]       ex_w, ey_w;
    logic        [32:0]       magx_w, magy_w;
    logic        [SUM_W-1:0]  rsum_w;

    cpec_pair_t               pair1_reg;
    logic        [NEAR_W-1:0] mex1_reg, mey1_reg, mex1_next, mey1_next;
    logic signed [NEAR_W:0]   ex1_reg, ey1_reg;
    logic                     gate1_reg, gate1_next;
    logic        [SUM_W-1:0]  lim1_reg, lim1_next, rsum1_reg;
    logic signed [32:0]       dvx1_reg, dvy1_reg, dvx1_next, dvy1_next;
    logic        [31:0]       am1_reg, bm1_reg, am1_next, bm1_next;

    always_comb
    begin
        ex_w       = 33'(pair.a_pos_x) - 33'(pair.b_pos_x);
        ey_w       = 33'(pair.a_pos_y) - 33'(pair.b_pos_y);
        magx_w     = ex_w[32] ? 33'(-ex_w) : 33'(ex_w);
        magy_w     = ey_w[32] ? 33'(-ey_w) : 33'(ey_w);
        rsum_w     = {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
        mex1_next  = magx_w[NEAR_W-1:0];
        mey1_next  = magy_w[NEAR_W-1:0];
        // far apart on either axis, or a radius sum below epsilon: no overlap
        gate1_next = (magx_w[32:NEAR_W] == '0) && (magy_w[32:NEAR_W] == '0)
                     && (rsum_w >= EPS);
        lim1_next  = rsum_w - EPS;
        dvx1_next  = 33'(pair.a_vel_x) - 33'(pair.b_vel_x);
        dvy1_next  = 33'(pair.a_vel_y) - 33'(pair.b_vel_y);
        // zero mass counts as one lsb
        am1_next   = (pair.a_mass == '0) ? 32'd1 : pair.a_mass;
        bm1_next   = (pair.b_mass == '0) ? 32'd1 : pair.b_mass;
    end

    always_ff @(posedge clk)
    begin
        pair1_reg <= pair;
        mex1_reg  <= mex1_next;
        mey1_reg  <= mey1_next;
        ex1_reg   <= ex_w[NEAR_W:0];
        ey1_reg   <= ey_w[NEAR_W:0];
        gate1_reg <= gate1_next;
        lim1_reg  <= lim1_next;
        rsum1_reg <= rsum_w;
        dvx1_reg  <= dvx1_next;
        dvy1_reg  <= dvy1_next;
        am1_reg   <= am1_next;
        bm1_reg   <= bm1_next;
    end

    // ------------------------------------------------------------------
    // stage 2: squares and dot product terms
    // ------------------------------------------------------------------
    cpec_pair_t               pair2_reg;
    logic        [NEAR_W-1:0] mex2_reg, mey2_reg;
    logic                     negx2_reg, negy2_reg, gate2_reg;
    logic        [SUM_W-1:0]  rsum2_reg;
    logic        [31:0]       am2_reg, bm2_reg;
    logic        [LIM2_W-1:0] sqx2_reg, sqy2_reg, lim2_reg;
    logic        [LIM2_W-1:0] sqx2_next, sqy2_next, lim2_next;
    logic signed [PRD_W-1:0]  px2_reg, py2_reg, px2_next, py2_next;

    always_comb
    begin
        sqx2_next = LIM2_W'(mex1_reg) * LIM2_W'(mex1_reg);
        sqy2_next = LIM2_W'(mey1_reg) * LIM2_W'(mey1_reg);
        lim2_next = LIM2_W'(lim1_reg) * LIM2_W'(lim1_reg);
        px2_next  = PRD_W'(dvx1_reg) * PRD_W'(ex1_reg);
        py2_next  = PRD_W'(dvy1_reg) * PRD_W'(ey1_reg);
    end

    always_ff @(posedge clk)
    begin
        pair2_reg <= pair1_reg;
        mex2_reg  <= mex1_reg;
        mey2_reg  <= mey1_reg;
        negx2_reg <= ex1_reg[NEAR_W];
        negy2_reg <= ey1_reg[NEAR_W];
        gate2_reg <= gate1_reg;
        rsum2_reg <= rsum1_reg;
        am2_reg   <= am1_reg;
        bm2_reg   <= bm1_reg;
        sqx2_reg  <= sqx2_next;
        sqy2_reg  <= sqy2_next;
        lim2_reg  <= lim2_next;
        px2_reg   <= px2_next;
        py2_reg   <= py2_next;
    end

    // ------------------------------------------------------------------
    // stage 3: d2, dot, overlap decision
    // ------------------------------------------------------------------
    logic        [D2_W-1:0]   d2_w;
    logic signed [DOT_W-1:0]  dot_w;
    logic                     hit_w;

    cpec_keep_t               keep3_reg, keep3_next;
    logic        [D2_W-1:0]   d2_3_reg;
    logic        [DOT_W-1:0]  mdot3_reg, mdot3_next;
    logic        [NEAR_W-1:0] mex3_reg, mey3_reg;
    logic        [SUM_W-1:0]  rsum3_reg;
    logic        [MO_W-1:0]   am2x3_reg, bm2x3_reg, msum3_reg, msum3_next;

    always_comb
    begin
        d2_w       = D2_W'(sqx2_reg) + D2_W'(sqy2_reg);
        dot_w      = DOT_W'(px2_reg) + DOT_W'(py2_reg);
        hit_w      = gate2_reg && (d2_w <= D2_W'(lim2_reg));
        mdot3_next = dot_w[DOT_W-1] ? DOT_W'(-dot_w) : DOT_W'(dot_w);
        msum3_next = MO_W'(am2_reg) + MO_W'(bm2_reg);

        keep3_next.ax         = pair2_reg.a_pos_x;
        keep3_next.ay         = pair2_reg.a_pos_y;
        keep3_next.avx        = pair2_reg.a_vel_x;
        keep3_next.avy        = pair2_reg.a_vel_y;
        keep3_next.bx         = pair2_reg.b_pos_x;
        keep3_next.by         = pair2_reg.b_pos_y;
        keep3_next.bvx        = pair2_reg.b_vel_x;
        keep3_next.bvy        = pair2_reg.b_vel_y;
        // equal centres leave the pair as it was
        keep3_next.collided   = hit_w && (d2_w != '0);
        keep3_next.coincident = hit_w && (d2_w == '0);
        keep3_next.neg_x      = negx2_reg;
        keep3_next.neg_y      = negy2_reg;
        keep3_next.neg_dot    = dot_w[DOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        keep3_reg <= keep3_next;
        d2_3_reg  <= d2_w;
        mdot3_reg <= mdot3_next;
        mex3_reg  <= mex2_reg;
        mey3_reg  <= mey2_reg;
        rsum3_reg <= rsum2_reg;
        am2x3_reg <= {am2_reg, 1'b0};
        bm2x3_reg <= {bm2_reg, 1'b0};
        msum3_reg <= msum3_next;
    end

    // ------------------------------------------------------------------
    // velocity path: |e| * |dot|, split in two halves of the dot
    // ------------------------------------------------------------------
    localparam int PP_W = NEAR_W + HALF_W;

    logic [PP_W-1:0] pxl4_reg, pxh4_reg, pyl4_reg, pyh4_reg;
    logic [P_W-1:0]  px5_reg, py5_reg;
    logic [D2_W-1:0] d2_5_reg;

    always_ff @(posedge clk)
    begin
        pxl4_reg <= PP_W'(mex3_reg) * PP_W'(mdot3_reg[HALF_W-1:0]);
        pxh4_reg <= PP_W'(mex3_reg) * PP_W'(mdot3_reg[DOT_W-1:HALF_W]);
        pyl4_reg <= PP_W'(mey3_reg) * PP_W'(mdot3_reg[HALF_W-1:0]);
        pyh4_reg <= PP_W'(mey3_reg) * PP_W'(mdot3_reg[DOT_W-1:HALF_W]);
    end

    always_ff @(posedge clk)
    begin
        px5_reg <= (P_W'(pxh4_reg) << HALF_W) + P_W'(pxl4_reg);
        py5_reg <= (P_W'(pyh4_reg) << HALF_W) + P_W'(pyl4_reg);
    end

    cpec_delay #(.W(D2_W), .DEPTH(2)) u_d2_dly (
        .clk (clk),
        .d   (d2_3_reg),
        .q   (d2_5_reg)
    );

    // q = floor(|e| * |dot| * 2^FRAC_BITS / d2), low bits kept
    logic [Q_W-1:0] qx, qy;

    cpec_div #(.NUM_W(NQ_W), .DEN_W(D2_W), .QUO_W(Q_W)) u_qx_div (
        .clk (clk),
        .num ({px5_reg, {FRAC_BITS{1'b0}}}),
        .den (d2_5_reg),
        .quo (qx)
    );

    cpec_div #(.NUM_W(NQ_W), .DEN_W(D2_W), .QUO_W(Q_W)) u_qy_div (
        .clk (clk),
        .num ({py5_reg, {FRAC_BITS{1'b0}}}),
        .den (d2_5_reg),
        .quo (qy)
    );

    // masses wait for the first quotient
    logic [3*MO_W-1:0] mass_q;
    logic [MO_W-1:0]   am2x_q, bm2x_q, msum_q;

    cpec_delay #(.W(3*MO_W), .DEPTH(T_Q - T_S3)) u_mass_dly (
        .clk (clk),
        .d   ({am2x3_reg, bm2x3_reg, msum3_reg}),
        .q   (mass_q)
    );

    assign {am2x_q, bm2x_q, msum_q} = mass_q;

    // q * 2 m_other in two partial products, then sum with the rounding term
    localparam int PM_W = 32 + MO_W;

    logic [PM_W-1:0] axl_reg, axh_reg, ayl_reg, ayh_reg;
    logic [PM_W-1:0] bxl_reg, bxh_reg, byl_reg, byh_reg;
    logic [MO_W-1:0] msum_m1_reg, msum_m2_reg;
    logic [M_W-1:0]  max_reg, may_reg, mbx_reg, mby_reg;
    logic [M_W-1:0]  rnd_w;

    always_ff @(posedge clk)
    begin
        axl_reg     <= PM_W'(qx[31:0])  * PM_W'(bm2x_q);
        axh_reg     <= PM_W'(qx[63:32]) * PM_W'(bm2x_q);
        ayl_reg     <= PM_W'(qy[31:0])  * PM_W'(bm2x_q);
        ayh_reg     <= PM_W'(qy[63:32]) * PM_W'(bm2x_q);
        bxl_reg     <= PM_W'(qx[31:0])  * PM_W'(am2x_q);
        bxh_reg     <= PM_W'(qx[63:32]) * PM_W'(am2x_q);
        byl_reg     <= PM_W'(qy[31:0])  * PM_W'(am2x_q);
        byh_reg     <= PM_W'(qy[63:32]) * PM_W'(am2x_q);
        msum_m1_reg <= msum_q;
    end

    // half of the divisor, for round half up
    assign rnd_w = M_W'(msum_m1_reg) << (FRAC_BITS - 1);

    always_ff @(posedge clk)
    begin
        max_reg     <= (M_W'(axh_reg) << 32) + M_W'(axl_reg) + rnd_w;
        may_reg     <= (M_W'(ayh_reg) << 32) + M_W'(ayl_reg) + rnd_w;
        mbx_reg     <= (M_W'(bxh_reg) << 32) + M_W'(bxl_reg) + rnd_w;
        mby_reg     <= (M_W'(byh_reg) << 32) + M_W'(byl_reg) + rnd_w;
        msum_m2_reg <= msum_m1_reg;
    end

    logic [DR_W-1:0] rden_w;
    logic [Q_W-1:0]  rax, ray, rbx, rby;

    assign rden_w = {msum_m2_reg, {FRAC_BITS{1'b0}}};

    cpec_div #(.NUM_W(M_W), .DEN_W(DR_W), .QUO_W(Q_W)) u_rax_div (
        .clk (clk),
        .num (max_reg),
        .den (rden_w),
        .quo (rax)
    );

    cpec_div #(.NUM_W(M_W), .DEN_W(DR_W), .QUO_W(Q_W)) u_ray_div (
        .clk (clk),
        .num (may_reg),
        .den (rden_w),
        .quo (ray)
    );

    cpec_div #(.NUM_W(M_W), .DEN_W(DR_W), .QUO_W(Q_W)) u_rbx_div (
        .clk (clk),
        .num (mbx_reg),
        .den (rden_w),
        .quo (rbx)
    );

    cpec_div #(.NUM_W(M_W), .DEN_W(DR_W), .QUO_W(Q_W)) u_rby_div (
        .clk (clk),
        .num (mby_reg),
        .den (rden_w),
        .quo (rby)
    );

    // ------------------------------------------------------------------
    // push path: dist = floor(sqrt(d2)), shift = |e| * (rsum - dist) / 2 dist
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]                 dist_w;
    logic [2*NEAR_W+SUM_W-1:0]         geo_q;
    logic [NEAR_W-1:0]                 mex_q, mey_q;
    logic [SUM_W-1:0]                  rsum_q;

    cpec_isqrt #(.IN_W(D2_W)) u_root (
        .clk      (clk),
        .radicand (d2_3_reg),
        .root     (dist_w)
    );

    cpec_delay #(.W(2*NEAR_W+SUM_W), .DEPTH(ROOT_W)) u_geo_dly (
        .clk (clk),
        .d   ({mex3_reg, mey3_reg, rsum3_reg}),
        .q   (geo_q)
    );

    assign {mex_q, mey_q, rsum_q} = geo_q;

    logic [ROOT_W-1:0] full_p1_reg, dist_p1_reg;
    logic [NEAR_W-1:0] mex_p1_reg, mey_p1_reg;
    logic [PN_W-1:0]   nx_p2_reg, ny_p2_reg;
    logic [PD_W-1:0]   den_p2_reg;

    always_ff @(posedge clk)
    begin
        full_p1_reg <= ROOT_W'(rsum_q) - dist_w;
        dist_p1_reg <= dist_w;
        mex_p1_reg  <= mex_q;
        mey_p1_reg  <= mey_q;
    end

    // adding dist is the rounding half of the 2 dist divisor
    always_ff @(posedge clk)
    begin
        nx_p2_reg  <= PN_W'(mex_p1_reg) * PN_W'(full_p1_reg) + PN_W'(dist_p1_reg);
        ny_p2_reg  <= PN_W'(mey_p1_reg) * PN_W'(full_p1_reg) + PN_W'(dist_p1_reg);
        den_p2_reg <= {dist_p1_reg, 1'b0};
    end

    logic [SH_W-1:0] shx_w, shy_w, shx_r, shy_r;

    cpec_div #(.NUM_W(PN_W), .DEN_W(PD_W), .QUO_W(SH_W)) u_shx_div (
        .clk (clk),
        .num (nx_p2_reg),
        .den (den_p2_reg),
        .quo (shx_w)
    );

    cpec_div #(.NUM_W(PN_W), .DEN_W(PD_W), .QUO_W(SH_W)) u_shy_div (
        .clk (clk),
        .num (ny_p2_reg),
        .den (den_p2_reg),
        .quo (shy_w)
    );

    cpec_delay #(.W(2*SH_W), .DEPTH(T_R - T_SH)) u_sh_dly (
        .clk (clk),
        .d   ({shx_w, shy_w}),
        .q   ({shx_r, shy_r})
    );

    // originals and flags wait for the velocity path
    logic [KW-1:0] keep_q;
    cpec_keep_t    keep_tr;

    cpec_delay #(.W(KW), .DEPTH(T_R - T_S3)) u_keep_dly (
        .clk (clk),
        .d   (keep3_reg),
        .q   (keep_q)
    );

    assign keep_tr = cpec_keep_t'(keep_q);

    // ------------------------------------------------------------------
    // output stage: sign, apply, saturate
    // ------------------------------------------------------------------
    logic signed [63:0] chg_ax, chg_ay, chg_bx, chg_by, shx64, shy64;
    cpec_result_t       result_reg, result_next;

    always_comb
    begin
        // velocity change carries the sign of e_c * dot, wraps at 64 bits
        chg_ax = (keep_tr.neg_x ^ keep_tr.neg_dot) ? -$signed(rax) : $signed(rax);
        chg_ay = (keep_tr.neg_y ^ keep_tr.neg_dot) ? -$signed(ray) : $signed(ray);
        chg_bx = (keep_tr.neg_x ^ keep_tr.neg_dot) ? -$signed(rbx) : $signed(rbx);
        chg_by = (keep_tr.neg_y ^ keep_tr.neg_dot) ? -$signed(rby) : $signed(rby);
        shx64  = keep_tr.neg_x ? -$signed({{(64-SH_W){1'b0}}, shx_r})
                               :  $signed({{(64-SH_W){1'b0}}, shx_r});
        shy64  = keep_tr.neg_y ? -$signed({{(64-SH_W){1'b0}}, shy_r})
                               :  $signed({{(64-SH_W){1'b0}}, shy_r});

        result_next.collided   = keep_tr.collided;
        result_next.coincident = keep_tr.coincident;
        if (keep_tr.collided)
        begin
            result_next.new_a_pos_x = sat32(64'(keep_tr.ax) + shx64);
            result_next.new_a_pos_y = sat32(64'(keep_tr.ay) + shy64);
            result_next.new_b_pos_x = sat32(64'(keep_tr.bx) - shx64);
            result_next.new_b_pos_y = sat32(64'(keep_tr.by) - shy64);
            result_next.new_a_vel_x = sat32(64'(keep_tr.avx) - chg_ax);
            result_next.new_a_vel_y = sat32(64'(keep_tr.avy) - chg_ay);
            result_next.new_b_vel_x = sat32(64'(keep_tr.bvx) + chg_bx);
            result_next.new_b_vel_y = sat32(64'(keep_tr.bvy) + chg_by);
        end
        else
        begin
            result_next.new_a_pos_x = keep_tr.ax;
            result_next.new_a_pos_y = keep_tr.ay;
            result_next.new_b_pos_x = keep_tr.bx;
            result_next.new_b_pos_y = keep_tr.by;
            result_next.new_a_vel_x = keep_tr.avx;
            result_next.new_a_vel_y = keep_tr.avy;
            result_next.new_b_vel_x = keep_tr.bvx;
            result_next.new_b_vel_y = keep_tr.bvy;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = valid_reg[LAT];

`ifndef ASSERT_OFF
    // every accepted item raises done at the end of the valid line
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("item did not complete at the expected latency");

    // a pair is never both resolved and coincident
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.collided && result.coincident))
        else $error("collided and coincident both set");

    // an unresolved pair leaves the output stage unchanged
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAT-1] && !keep_tr.collided |=>
            done && result.new_a_vel_x == $past(keep_tr.avx)
                 && result.new_b_pos_y == $past(keep_tr.by))
        else $error("unresolved pair was modified");
`endif

endmodule

/* hdl/cpec_delay.sv */
// ----------------------------------------------------------------------------
// cpec_delay
// fixed-length register line for data that waits on a longer branch
// ----------------------------------------------------------------------------
module cpec_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [1:DEPTH];

    always_ff @(posedge clk)
    begin
        line_reg[1] <= d;
        for (int i = 2; i <= DEPTH; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[DEPTH];

endmodule

/* hdl/cpec_div.sv */
// ----------------------------------------------------------------------------
// cpec_div
// pipelined restoring divider, one quotient bit per stage, low bits kept
// ----------------------------------------------------------------------------
module cpec_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int QUO_W = 8
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];
    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [QUO_W-1:0] quo_reg [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign num_in = num;
            assign den_in = den;
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign num_in = num_reg[k];
            assign den_in = den_reg[k];
            assign rem_in = rem_reg[k];
            assign quo_in = quo_reg[k];
        end

        // shift in the next numerator bit and try the subtract
        assign trial = {rem_in, num_in[NUM_W-1-k]};
        assign diff  = {1'b0, trial} - {2'b00, den_in};
        assign ge    = !diff[DEN_W+1];

        always_ff @(posedge clk)
        begin
            num_reg[k+1] <= num_in;
            den_reg[k+1] <= den_in;
            rem_reg[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg[k+1] <= {quo_in[QUO_W-2:0], ge};
        end
    end

    assign quo = quo_reg[NUM_W];

endmodule

/* hdl/cpec_isqrt.sv */
// ----------------------------------------------------------------------------
// cpec_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module cpec_isqrt #(
    parameter int IN_W = 8
) (
    input  logic                     clk,
    input  logic [IN_W-1:0]          radicand,
    output logic [(IN_W+1)/2-1:0]    root
);

    localparam int STEPS = (IN_W + 1) / 2;

    logic [IN_W-1:0] rad_reg [1:STEPS];
    logic [IN_W-1:0] res_reg [1:STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [IN_W-1:0] BIT_K =
            {{(IN_W-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));
        logic [IN_W-1:0] rad_in;
        logic [IN_W-1:0] res_in;
        logic [IN_W-1:0] tmp;

        if (k == 0)
        begin : g_first
            assign rad_in = radicand;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rad_in = rad_reg[k];
            assign res_in = res_reg[k];
        end

        assign tmp = res_in + BIT_K;

        always_ff @(posedge clk)
        begin
            if (rad_in >= tmp)
            begin
                rad_reg[k+1] <= rad_in - tmp;
                res_reg[k+1] <= (res_in >> 1) + BIT_K;
            end
            else
            begin
                rad_reg[k+1] <= rad_in;
                res_reg[k+1] <= res_in >> 1;
            end
        end
    end

    assign root = res_reg[STEPS][STEPS-1:0];

endmodule
